@@ rtl/core/ujwst_pkg.sv @@
// Shared definitions for the undo journal write set tracker.
// Holds field widths, action and status codes and register indexes.
// No dependencies; imported by the tracker top level (ujwst_ram does not use it).
`timescale 1ns / 1ps

package ujwst_pkg;

    // Default size of the entry table.
    localparam int MAX_ENTRIES_DEF = 16;

    // Field widths of one input item.
    localparam int ACTION_W = 3;
    localparam int SECTOR_W = 32;
    localparam int PORT_W   = 16;

    // Field widths of one result item.
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int COUNT_W  = 5;
    localparam int SEQ_W    = 32;

    // Stream payload widths, rounded up to whole bytes.
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 48;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLED      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_PORT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_MSTR  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_VOLUME_START = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_VOLUME_END   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNDO_AREA    = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIRROR       = 3'd7;

    // Actions.
    localparam logic [ACTION_W-1:0] ACT_READ       = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE      = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_BEGIN      = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_END_COMMIT = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_END_ABORT  = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DISK  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_HIT   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NEW   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_PROT  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_WRAP  = 3'd6;
    localparam logic [STATUS_W-1:0] ST_DEPTH = 3'd7;

endpackage

@@ rtl/core/ujwst_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the entry sector table; no package dependencies.
`timescale 1ns / 1ps

module ujwst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/undo_journal_write_set_tracker.sv @@
// Top level of the undo journal write set tracker.
// Depends on ujwst_pkg and on ujwst_ram for the entry sector table.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake          Payload
//  s_*       in         s_tvalid/s_tready  action, sector_addr, port, drive_is_master
//  m_*       out        m_tvalid/m_tready  status, slot, commit_now, commit_count,
//                                          sequence_out
//  cfg_*     in         cfg_we             cfg_index selects register, cfg_data value
//
// One item is worked on at a time. An item is taken in (S_IDLE), classified
// (S_EVAL) and its result handed to the output register (S_DONE).
// Reads and writes that reach the table also scan the entry memory at one entry
// per cycle (S_SCAN) until a hit or the end of the pending entries; the memory
// has registered read data, so each compare follows its read address.
// Reset (rst_n, asynchronous) clears the control state and the configuration
// registers. The table itself is not cleared, since only slots below the entry
// count are read; the payload and result registers are not cleared either.
// The output register holds a finished result while the next item is taken in;
// while it is stalled, the next item waits after classification and the input
// stays blocked.

module undo_journal_write_set_tracker
#(
    parameter int MAX_ENTRIES = ujwst_pkg::MAX_ENTRIES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input stream.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata: action[2:0], sector_addr[34:3], port[50:35], drive_is_master[51]
    input  logic [ujwst_pkg::IN_TDATA_W-1:0]   s_tdata,
    // Result stream.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata: status[2:0], slot[6:3], commit_now[7], commit_count[12:8],
    //          sequence_out[44:13]
    output logic [ujwst_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // Configuration write port.
    input  logic                               cfg_we,
    input  logic [ujwst_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ujwst_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import ujwst_pkg::*;

    // Slot index width and entry count width follow from the table size.
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);
    localparam logic [SECTOR_W:0] PROT_SPAN = (SECTOR_W + 1)'(MAX_ENTRIES);

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    // A result without its sequence number, which is read at hand-off.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IW-1:0]       slot;
        logic                commit_now;
        logic [CW-1:0]       commit_count;
    } pend_t;

    // Configuration registers.
    logic                enabled_reg;
    logic [PORT_W-1:0]   dev_port_reg;
    logic                dev_master_reg;
    logic [SECTOR_W-1:0] vol_start_reg;
    logic [SECTOR_W-1:0] vol_end_reg;
    logic [SECTOR_W-1:0] header_reg;
    logic [SECTOR_W-1:0] undo_reg;
    logic [SECTOR_W-1:0] mirror_reg;

    // Sequencer and journal state.
    logic [1:0]          state_reg, state_next;
    logic [31:0]         depth_reg, depth_next;
    logic [CW-1:0]       total_reg, total_next;
    logic [SEQ_W-1:0]    seq_reg, seq_next;

    // The item at work.
    logic [ACTION_W-1:0] act_reg;
    logic [SECTOR_W-1:0] addr_reg;
    logic [PORT_W-1:0]   port_reg;
    logic                mst_reg;

    // Scan control.
    logic                auto_reg, auto_next;
    logic [CW-1:0]       tot_reg, tot_next;
    logic [CW-1:0]       iss_reg, iss_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]       cmp_idx_reg, cmp_idx_next;

    // Result registers.
    pend_t               pend_reg, pend_next;
    pend_t               out_reg;
    logic [SEQ_W-1:0]    out_seq_reg;
    logic                out_vld_reg, out_vld_next;
    logic                out_load;

    // Entry table port.
    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    logic                ram_re;
    logic [IW-1:0]       ram_raddr;
    logic [SECTOR_W-1:0] ram_rdata;

    // Classification of the item at work.
    logic                own_drive;
    logic                outside_volume;
    logic                protected_hit;
    logic                hit;
    logic                miss;
    logic [CW-1:0]       new_total;
    logic                good;
    logic [IW+SLOT_W-1:0]  slot_wide;
    logic [CW+COUNT_W-1:0] count_wide;

    ujwst_ram #(
        .WIDTH (SECTOR_W),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (addr_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign own_drive      = (port_reg == dev_port_reg) && (mst_reg == dev_master_reg);
    assign outside_volume = (addr_reg < vol_start_reg) || (addr_reg >= vol_end_reg);
    // The end of the protected range is taken one bit wider so it cannot wrap.
    assign protected_hit  = ((addr_reg >= header_reg) &&
                             ({1'b0, addr_reg} < ({1'b0, undo_reg} + PROT_SPAN))) ||
                            (addr_reg == mirror_reg);

    // The memory answers in the cycle after the address; cmp_* tracks that entry.
    assign ram_re    = (state_reg == S_SCAN) && (iss_reg < tot_reg);
    assign ram_raddr = iss_reg[IW-1:0];
    assign hit       = (state_reg == S_SCAN) && cmp_vld_reg && (ram_rdata == addr_reg);
    assign miss      = (state_reg == S_SCAN) && !cmp_vld_reg && (iss_reg >= tot_reg);

    assign s_tready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_DONE) && (!out_vld_reg || m_tready);

    always_comb
    begin
        state_next   = state_reg;
        depth_next   = depth_reg;
        total_next   = total_reg;
        seq_next     = seq_reg;
        auto_next    = auto_reg;
        tot_next     = tot_reg;
        iss_next     = iss_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = iss_reg[IW-1:0];
        pend_next    = pend_reg;
        ram_we       = 1'b0;
        ram_waddr    = tot_reg[IW-1:0];
        new_total    = tot_reg;
        good         = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                pend_next  = '{status: ST_OK, slot: '0, commit_now: 1'b0,
                               commit_count: '0};
                state_next = S_DONE;
                iss_next   = '0;
                auto_next  = 1'b0;
                unique case (act_reg)
                    ACT_READ:
                    begin
                        pend_next.status = ST_DISK;
                        if (enabled_reg && (depth_reg != '0) && own_drive)
                        begin
                            tot_next   = total_reg;
                            state_next = S_SCAN;
                        end
                    end
                    ACT_WRITE:
                    begin
                        if (!enabled_reg || !own_drive || outside_volume)
                        begin
                            pend_next.status = ST_DISK;
                        end
                        else if (protected_hit)
                        begin
                            pend_next.status = ST_PROT;
                        end
                        else
                        begin
                            // A write outside any transaction runs in one of its own
                            // that starts empty.
                            auto_next  = (depth_reg == '0);
                            tot_next   = (depth_reg == '0) ? '0 : total_reg;
                            state_next = S_SCAN;
                        end
                    end
                    ACT_BEGIN:
                    begin
                        if (&depth_reg)
                        begin
                            pend_next.status = ST_DEPTH;
                        end
                        else
                        begin
                            if (depth_reg == '0)
                            begin
                                total_next = '0;
                            end
                            depth_next = depth_reg + 32'd1;
                        end
                    end
                    ACT_END_COMMIT, ACT_END_ABORT:
                    begin
                        if (depth_reg == '0)
                        begin
                            pend_next.status = ST_DEPTH;
                        end
                        else
                        begin
                            depth_next = depth_reg - 32'd1;
                            if (depth_reg == 32'd1)
                            begin
                                // Leaving the outermost level drops the write set.
                                if (enabled_reg && (act_reg == ACT_END_COMMIT) &&
                                    (total_reg != '0))
                                begin
                                    pend_next.commit_now   = 1'b1;
                                    pend_next.commit_count = total_reg;
                                end
                                total_next = '0;
                            end
                        end
                    end
                    default:
                    begin
                        pend_next.status = ST_OK;
                    end
                endcase
            end

            S_SCAN:
            begin
                if (ram_re)
                begin
                    iss_next     = iss_reg + CW'(1);
                    cmp_vld_next = 1'b1;
                end
                if (hit || miss)
                begin
                    state_next = S_DONE;
                    if (hit)
                    begin
                        pend_next.status = ST_HIT;
                        pend_next.slot   = cmp_idx_reg;
                    end
                    else if (act_reg == ACT_READ)
                    begin
                        pend_next.status = ST_DISK;
                    end
                    else if (tot_reg >= MAX_CNT)
                    begin
                        pend_next.status = ST_FULL;
                        good             = 1'b0;
                    end
                    else
                    begin
                        // Append a new slot; the first slot of a transaction
                        // advances the sequence number.
                        ram_we           = 1'b1;
                        new_total        = tot_reg + CW'(1);
                        pend_next.status = ST_NEW;
                        pend_next.slot   = tot_reg[IW-1:0];
                        if (tot_reg == '0)
                        begin
                            seq_next = seq_reg + SEQ_W'(1);
                            if (&seq_reg)
                            begin
                                pend_next.status = ST_WRAP;
                                good             = 1'b0;
                            end
                        end
                    end

                    if (act_reg == ACT_WRITE)
                    begin
                        if (auto_reg)
                        begin
                            // The self-opened transaction closes at once.
                            if (good && (new_total != '0))
                            begin
                                pend_next.commit_now   = 1'b1;
                                pend_next.commit_count = new_total;
                            end
                            total_next = '0;
                        end
                        else
                        begin
                            total_next = new_total;
                        end
                    end
                end
            end

            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (out_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg    <= 1'b0;
            dev_port_reg   <= '0;
            dev_master_reg <= 1'b0;
            vol_start_reg  <= '0;
            vol_end_reg    <= '0;
            header_reg     <= '0;
            undo_reg       <= '0;
            mirror_reg     <= '0;
            state_reg      <= S_IDLE;
            depth_reg      <= '0;
            total_reg      <= '0;
            seq_reg        <= '0;
            auto_reg       <= 1'b0;
            tot_reg        <= '0;
            iss_reg        <= '0;
            cmp_vld_reg    <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ENABLED:      enabled_reg    <= cfg_data[0];
                    CFG_DEVICE_PORT:  dev_port_reg   <= cfg_data[PORT_W-1:0];
                    CFG_DEVICE_MSTR:  dev_master_reg <= cfg_data[0];
                    CFG_VOLUME_START: vol_start_reg  <= cfg_data;
                    CFG_VOLUME_END:   vol_end_reg    <= cfg_data;
                    CFG_HEADER:       header_reg     <= cfg_data;
                    CFG_UNDO_AREA:    undo_reg       <= cfg_data;
                    CFG_MIRROR:       mirror_reg     <= cfg_data;
                    default:          enabled_reg    <= enabled_reg;
                endcase
            end
            state_reg   <= state_next;
            depth_reg   <= depth_next;
            total_reg   <= total_next;
            seq_reg     <= seq_next;
            auto_reg    <= auto_next;
            tot_reg     <= tot_next;
            iss_reg     <= iss_next;
            cmp_vld_reg <= cmp_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            act_reg  <= s_tdata[2:0];
            addr_reg <= s_tdata[34:3];
            port_reg <= s_tdata[50:35];
            mst_reg  <= s_tdata[51];
        end
        cmp_idx_reg <= cmp_idx_next;
        pend_reg    <= pend_next;
        if (out_load)
        begin
            out_reg     <= pend_reg;
            out_seq_reg <= seq_reg;
        end
    end

    // Slot and count ports are narrower than a large table's indexes.
    assign slot_wide  = {{SLOT_W{1'b0}}, out_reg.slot};
    assign count_wide = {{COUNT_W{1'b0}}, out_reg.commit_count};

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {3'b000, out_seq_reg, count_wide[COUNT_W-1:0], out_reg.commit_now,
                       slot_wide[SLOT_W-1:0], out_reg.status};

`ifndef NO_ASSERTIONS
    // Outside every transaction the write set is empty.
    a_empty_outside: assert property (@(posedge clk) disable iff (!rst_n)
        (depth_reg == '0) |-> (total_reg == '0))
        else $error("entries pending outside a transaction");

    // The entry count never exceeds the table.
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (total_reg <= MAX_CNT))
        else $error("entry count beyond table size");

    // An append inside an open transaction grows the write set by one.
    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && !auto_reg) |=> (total_reg == $past(total_reg) + CW'(1)))
        else $error("append did not advance the entry count");

    // Only hits, new slots and sequence wraps report a slot number.
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && (out_reg.status != ST_HIT) && (out_reg.status != ST_NEW) &&
         (out_reg.status != ST_WRAP)) |-> (out_reg.slot == '0))
        else $error("slot reported without a hit or allocation");
`endif

endmodule
